// ----- rtl/flow_tuple_hash_top_defines.svh -----
// Assertion macros shared by the flow tuple hash checker.
// Depends on nothing; included by files that carry assertions.
`ifndef FLOW_TUPLE_HASH_TOP_DEFINES_SVH
`define FLOW_TUPLE_HASH_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define FTH_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("flow tuple hash check failed");

// Check that cons holds in the cycle after ante.
`define FTH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("flow tuple hash check failed");

`endif

// ----- rtl/fth_pkg.sv -----
// Shared types and constants of the flow tuple hash.
// No dependencies; imported by every module of the block.
package fth_pkg;

    localparam int NUM_STEPS    = 12;
    localparam int TUNNEL_STEPS = 8;
    localparam int RES_W        = 24;

    localparam logic [RES_W-1:0] HASH_MOD = 24'hFF_100F;

    // Register reset values
    localparam logic [47:0] RESET_ORDER    = 48'h0A64_7193_B852;
    localparam logic [63:0] RESET_KEY_LOW  = 64'h231A_0D0C_1513_2519;
    localparam logic [31:0] RESET_KEY_HIGH = 32'h110F_140E;

    typedef enum logic [1:0] {
        REG_ORDER    = 2'd0,
        REG_KEY_LOW  = 2'd1,
        REG_KEY_HIGH = 2'd2
    } t_reg_index;

    typedef logic [RES_W-1:0] t_res;
    typedef logic [NUM_STEPS-1:0][7:0] t_byte_arr;

    // What travels down the pipe beside the residue
    typedef struct packed {
        logic      mode;
        t_byte_arr bytes;
    } t_carry;

endpackage

// ----- rtl/fth_stage.sv -----
// One pipeline stage of the flow tuple hash: a single modular byte step.
// Depends on fth_pkg.
module fth_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic           i_apply,
    input  logic [7:0]     i_byte,
    input  fth_pkg::t_carry i_carry,
    input  fth_pkg::t_res  i_res,
    output logic           o_valid,
    output fth_pkg::t_carry o_carry,
    output fth_pkg::t_res  o_res
);
    import fth_pkg::*;

    // 2^24 folded back below the modulus
    localparam logic [15:0] WRAP_MUL = 16'(25'h100_0000 - {1'b0, HASH_MOD});

    logic            r_valid;
    t_carry          r_carry;
    t_res            r_res;
    t_res            n_res;
    logic [RES_W-1:0] w_prod;
    logic [RES_W:0]   w_sum;
    logic [RES_W:0]   w_diff;

    // Fold the top byte, append the new byte, one conditional subtract
    always_comb begin
        w_prod = {16'b0, i_res[23:16]} * {8'b0, WRAP_MUL};
        w_sum  = {1'b0, w_prod} + {1'b0, i_res[15:0], i_byte};
        w_diff = w_sum - {1'b0, HASH_MOD};
        if (!i_apply) begin
            n_res = i_res;
        end else if (w_sum >= {1'b0, HASH_MOD}) begin
            n_res = w_diff[RES_W-1:0];
        end else begin
            n_res = w_sum[RES_W-1:0];
        end
    end

    // Valid travels with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_carry <= i_carry;
            r_res   <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_carry = r_carry;
    assign o_res   = r_res;

endmodule

// ----- rtl/flow_tuple_hash_top.sv -----
// Top level of the flow tuple hash: byte selection stage and twelve step stages.
// Depends on fth_pkg and fth_stage.
//
// Takes one connection key per cycle unless stalled and presents its 24-bit hash. One
// stage picks and masks the twelve key bytes through the permutation table. Then twelve
// stages each run one byte step of the residue modulo 0xFF100F, tunnel keys only the first
// TUNNEL_STEPS. Empty stages close up under a stall on the result side, so keys enter until
// every stage is full. Write configuration through i_cfg_we / i_cfg_index / i_cfg_data
// only with no transaction in flight; the block does not enforce it. Index 3 is ignored.
module flow_tuple_hash_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    // key channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [31:0]          i_source_address,
    input  logic [31:0]          i_dest_address,
    input  logic [15:0]          i_source_port,
    input  logic [15:0]          i_dest_port,
    // hash channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [fth_pkg::RES_W-1:0] o_hash_value
);
    import fth_pkg::*;

    logic [47:0] r_order;
    logic [63:0] r_key_low;
    logic [31:0] r_key_high;

    logic        r_sel_valid;
    t_carry      r_sel_carry;
    t_carry      n_sel_carry;
    t_byte_arr   w_key_bytes;
    t_byte_arr   w_in_bytes;

    logic        w_valid [0:NUM_STEPS];
    t_carry      w_carry [0:NUM_STEPS];
    t_res        w_res   [0:NUM_STEPS];
    logic        w_en    [0:NUM_STEPS+1];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order    <= RESET_ORDER;
            r_key_low  <= RESET_KEY_LOW;
            r_key_high <= RESET_KEY_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ORDER:    r_order    <= i_cfg_data[47:0];
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_KEY_HIGH: r_key_high <= i_cfg_data[31:0];
                default:      ;
            endcase
        end
    end

    // Lay out the key little-endian and pick each step's byte
    always_comb begin
        logic [3:0] idx;
        logic       in_range;
        w_in_bytes  = {i_dest_port, i_source_port, i_dest_address, i_source_address};
        w_key_bytes = {r_key_high, r_key_low};
        n_sel_carry.mode = i_mode;
        for (int k = 0; k < NUM_STEPS; k++) begin
            idx      = r_order[4*k +: 4];
            in_range = i_mode ? (idx < 4'(TUNNEL_STEPS)) : (idx < 4'(NUM_STEPS));
            n_sel_carry.bytes[k] = (in_range ? w_in_bytes[idx] : 8'h00) ^ w_key_bytes[k];
        end
    end

    // Each stage advances when it is empty or its successor advances
    assign w_en[NUM_STEPS+1] = !i_out_stall;
    for (genvar j = 0; j <= NUM_STEPS; j++) begin : g_en
        assign w_en[j] = !w_valid[j] || w_en[j+1];
    end

    // Selection stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_valid <= 1'b0;
        end else if (w_en[0]) begin
            r_sel_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_sel_carry <= n_sel_carry;
        end
    end

    assign w_valid[0] = r_sel_valid;
    assign w_carry[0] = r_sel_carry;
    assign w_res[0]   = '0;

    // Step stages; tunnel keys skip the steps from TUNNEL_STEPS on
    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
        fth_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[k+1]),
            .i_valid (w_valid[k]),
            .i_apply (!(w_carry[k].mode && (k >= TUNNEL_STEPS))),
            .i_byte  (w_carry[k].bytes[k]),
            .i_carry (w_carry[k]),
            .i_res   (w_res[k]),
            .o_valid (w_valid[k+1]),
            .o_carry (w_carry[k+1]),
            .o_res   (w_res[k+1])
        );
    end

    assign o_in_stall   = !w_en[0];
    assign o_out_valid  = w_valid[NUM_STEPS];
    assign o_hash_value = w_res[NUM_STEPS];

endmodule

// ----- rtl/fth_checker.sv -----
// Port-level checks of the flow tuple hash, bound to the top level.
// Depends on fth_pkg and flow_tuple_hash_top_defines.svh.
`include "flow_tuple_hash_top_defines.svh"

module fth_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [fth_pkg::RES_W-1:0] o_hash_value
);
    import fth_pkg::*;

    // A waiting result holds its value
    `FTH_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_hash_value))

    // Every hash is a proper residue
    `FTH_ASSERT_SAME(a_residue, o_out_valid, o_hash_value < HASH_MOD)

    // An empty output stage means the whole pipe can advance
    `FTH_ASSERT_SAME(a_no_false_stall, !o_out_valid, !o_in_stall)

    // A taken output slot never blocks the input
    `FTH_ASSERT_SAME(a_flow_through, !i_out_stall, !o_in_stall)

endmodule

bind flow_tuple_hash_top fth_checker u_fth_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_hash_value (o_hash_value)
);

// ----- tb/sv/fth_hash_checker.sv -----
`timescale 1ns / 100ps
// Checker for the flow tuple hash: shadows the configuration registers, predicts each hash
// and compares it with the result channel. Depends on fth_pkg.
module fth_hash_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [63:0]               i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_mode,
    input  logic [31:0]               i_source_address,
    input  logic [31:0]               i_dest_address,
    input  logic [15:0]               i_source_port,
    input  logic [15:0]               i_dest_port,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [fth_pkg::RES_W-1:0] i_hash_value,
    output int                        o_fail_count,
    output int                        o_pending
);
    import fth_pkg::*;

    // Shadow copies of the configuration registers
    logic [47:0] byte_order;
    logic [63:0] xor_low;
    logic [31:0] xor_high;

    t_res pending_hashes[$];
    int   mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    initial o_pending = 0;

    // Print one line per mismatch and count it
    task automatic log_mismatch(input string what);
        $display("%0t hash check: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Residue of the permuted, key-masked byte sequence modulo HASH_MOD
    function automatic t_res tuple_hash(input logic tunnel, input logic [31:0] src,
                                        input logic [31:0] dst, input logic [15:0] sport,
                                        input logic [15:0] dport);
        logic [95:0] key_bytes;
        logic [95:0] mask_bytes;
        logic [31:0] acc;
        logic [7:0]  b;
        int unsigned steps;
        int unsigned idx;
        key_bytes  = {dport, sport, dst, src};
        mask_bytes = {xor_high, xor_low};
        steps      = tunnel ? TUNNEL_STEPS : NUM_STEPS;
        acc        = '0;
        for (int s = 0; s < steps; s++) begin
            idx = 32'(byte_order[4*s +: 4]);
            // bytes outside the key of this mode read as zero
            b   = (idx < steps) ? key_bytes[8*idx +: 8] : 8'h00;
            b   = b ^ mask_bytes[8*s +: 8];
            acc = ((acc << 8) + 32'(b)) % 32'(HASH_MOD);
        end
        return acc[RES_W-1:0];
    endfunction

    // Track registers, queue predictions on input transactions, check output transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_order = RESET_ORDER;
            xor_low    = RESET_KEY_LOW;
            xor_high   = RESET_KEY_HIGH;
            pending_hashes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_hashes.size() == 0) begin
                    log_mismatch($sformatf("unexpected hash %h", i_hash_value));
                end else begin
                    t_res want;
                    want = pending_hashes.pop_front();
                    if (i_hash_value !== want)
                        log_mismatch($sformatf("hash_value %h, expected %h",
                                               i_hash_value, want));
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_hashes.push_back(tuple_hash(i_mode, i_source_address, i_dest_address,
                                                    i_source_port, i_dest_port));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ORDER:    byte_order = i_cfg_data[47:0];
                    REG_KEY_LOW:  xor_low    = i_cfg_data;
                    REG_KEY_HIGH: xor_high   = i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
        o_pending <= pending_hashes.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for flow_tuple_hash_top: drives keys, configuration and result stalls.
// Depends on fth_pkg, fth_hash_checker and the block's RTL.
module tb;
    import fth_pkg::*;

    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam int         STUCK_LIMIT = 2000;
    localparam int         LONG_HOLD   = 60;
    localparam int         PHASE_KEYS  = 125;
    localparam int         NUM_PHASES  = 6;
    localparam int         SETTLE      = 20;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_index = '0;
    logic [63:0]       i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_mode = 1'b0;
    logic [31:0]       i_source_address = '0;
    logic [31:0]       i_dest_address = '0;
    logic [15:0]       i_source_port = '0;
    logic [15:0]       i_dest_port = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [RES_W-1:0]  o_hash_value;

    int fail_count;
    int pending;
    int stuck_cycles = 0;
    int hold_req_cnt = 0;
    int hold_granted = 0;
    int hold_left = 0;
    int stall_style = 0;
    int style_cycle = 0;
    int burst_left = 0;

    flow_tuple_hash_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_source_address (i_source_address),
        .i_dest_address   (i_dest_address),
        .i_source_port    (i_source_port),
        .i_dest_port      (i_dest_port),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_hash_value     (o_hash_value)
    );

    fth_hash_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_source_address (i_source_address),
        .i_dest_address   (i_dest_address),
        .i_source_port    (i_source_port),
        .i_dest_port      (i_dest_port),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_hash_value     (o_hash_value),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side: long hold on request, else a stall style redrawn when style_cycle wraps
    always @(posedge i_clk) begin
        if (style_cycle == 96) begin
            style_cycle <= 0;
            stall_style <= $urandom_range(0, 3);
        end else begin
            style_cycle <= style_cycle + 1;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_granted != hold_req_cnt) begin
            hold_granted <= hold_req_cnt;
            hold_left    <= LONG_HOLD;
            i_out_stall  <= 1'b1;
        end else begin
            case (stall_style)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= style_cycle[0];
            endcase
        end
    end

    // Watchdog: end the run after too many cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 7))
            0: return 16'h0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Byte order table, either with indices inside the key or any nibble at all
    function automatic logic [63:0] pick_order(input bit any_nibble);
        logic [63:0] order;
        order = {$urandom, $urandom};
        if (!any_nibble)
            for (int s = 0; s < NUM_STEPS; s++)
                order[4*s +: 4] = 4'($urandom_range(0, 11));
        return order;
    endfunction

    // Offer one key, with a random gap before each new burst; return once accepted
    task automatic send_key(input logic mode, input logic [31:0] src, input logic [31:0] dst,
                            input logic [15:0] sport, input logic [15:0] dport);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid       <= 1'b1;
        i_mode           <= mode;
        i_source_address <= src;
        i_dest_address   <= dst;
        i_source_port    <= sport;
        i_dest_port      <= dport;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_random_key();
        send_key(1'($urandom_range(0, 1)), pick_word(), pick_word(), pick_port(), pick_port());
    endtask

    // Drop valid and wait until every predicted hash has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Write all three registers back to back, optionally the unused index too
    task automatic set_registers(input logic [63:0] order, input logic [63:0] key_low,
                                 input logic [63:0] key_high, input bit hit_unused);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_ORDER;
        i_cfg_data  <= order;
        @(posedge i_clk);
        i_cfg_index <= REG_KEY_LOW;
        i_cfg_data  <= key_low;
        @(posedge i_clk);
        i_cfg_index <= REG_KEY_HIGH;
        i_cfg_data  <= key_high;
        @(posedge i_clk);
        if (hit_unused) begin
            i_cfg_index <= REG_UNUSED;
            i_cfg_data  <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: field extremes; tunnel mode hits port indices in the table
        send_key(1'b0, 32'h0, 32'h0, 16'h0, 16'h0);
        send_key(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_key(1'b1, 32'h0, 32'h0, 16'h0, 16'h0);
        send_key(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_key(1'b0, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'h0);
        send_key(1'b0, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'h0);
        send_key(1'b0, 32'h0, 32'h0, 16'hFFFF, 16'h0);
        send_key(1'b0, 32'h0, 32'h0, 16'h0, 16'hFFFF);
        send_key(1'b1, 32'h0, 32'h0, 16'hFFFF, 16'hFFFF);
        send_key(1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 16'h5A5A, 16'hA5A5);
        send_key(1'b0, 32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h0001);
        send_key(1'b0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'hC3C3, 16'h3C3C);
        wait_drained();

        // Table with indices past the key, wide data with bits to drop, unused index
        set_registers(64'hFFFF_FEDC_BA98_7654, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_key(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_key(1'b0, 32'h0, 32'h0, 16'h0, 16'h0);
        send_key(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_key(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 16'h0);
        send_key(1'b0, 32'h0123_4567, 32'h89AB_CDEF, 16'h1357, 16'h2468);
        wait_drained();

        // Random keys under a series of register settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: set_registers(64'h0000_BA98_7654_3210, 64'h0, 64'h0, 1'b0);
                1: set_registers({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, 1'b0);
                2: set_registers(64'h0, 64'h0, 64'h0, 1'b1);
                3: set_registers(pick_order(1'b0), {$urandom, $urandom}, 64'($urandom), 1'b0);
                4: set_registers(pick_order(1'b1), {$urandom, $urandom},
                                 {$urandom, $urandom}, 1'b1);
                default: set_registers(pick_order(1'b0), {$urandom, $urandom},
                                       64'($urandom), 1'b0);
            endcase
            // hold off the result side while keys keep coming
            if (p == 1 || p == 4)
                hold_req_cnt <= hold_req_cnt + 1;
            repeat (PHASE_KEYS) send_random_key();
            wait_drained();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/fth_pkg.sv
rtl/fth_stage.sv
rtl/flow_tuple_hash_top.sv
rtl/fth_checker.sv
tb/sv/fth_hash_checker.sv
tb/sv/tb.sv
